// ===== design/rerl_pkg.sv =====
// rerl_pkg: constants shared by the resolved energy ratio limiter
// no dependencies
`timescale 1ns / 1ps
package rerl_pkg;

	// width at which intermediate quotients saturate
	localparam int SAT_W  = 64;
	localparam int HALF_W = 32;

	// 1.5 / 0.22 is exactly 75 / 11
	localparam int KOL_NUM   = 75;
	localparam int KOL_NUM_W = 7;
	localparam int KOL_DEN   = 11;
	localparam int KOL_DEN_W = 4;

endpackage

// ===== design/rerl_if.sv =====
// rerl channel interfaces: node request, ratio result and floor register write
// depends on nothing; widths come from interface parameters
`timescale 1ns / 1ps
interface rerl_in_if #(parameter int FIELD_WIDTH = 32) ();
	logic                   valid;
	logic                   ready;
	logic [FIELD_WIDTH-1:0] kinetic_energy;
	logic [FIELD_WIDTH-1:0] resolved_energy;
	logic [FIELD_WIDTH-1:0] dissipation_rate;
	logic [FIELD_WIDTH-1:0] molecular_viscosity;
	logic [FIELD_WIDTH-1:0] eddy_viscosity;
	modport source (output valid, kinetic_energy, resolved_energy, dissipation_rate,
		molecular_viscosity, eddy_viscosity, input ready);
	modport sink (input valid, kinetic_energy, resolved_energy, dissipation_rate,
		molecular_viscosity, eddy_viscosity, output ready);
endinterface

interface rerl_out_if #(parameter int FRACTION_BITS = 16) ();
	logic                   valid;
	logic                   ready;
	logic [FRACTION_BITS:0] energy_ratio;
	modport source (output valid, energy_ratio, input ready);
	modport sink (input valid, energy_ratio, output ready);
endinterface

interface rerl_cfg_if #(parameter int FRACTION_BITS = 16) ();
	logic                   valid;
	logic                   ready;
	logic [FRACTION_BITS:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== design/rerl_div.sv =====
// rerl_div: pipelined restoring divider, one quotient bit per stage, saturating
// standalone; used by resolved_energy_ratio_limiter
`timescale 1ns / 1ps
module rerl_div #(
	parameter int NW = 80,
	parameter int DW = 32,
	parameter int QW = 64,
	parameter int PW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_in,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [PW-1:0] pay_in,
	output logic          v_out,
	output logic [QW-1:0] quo,
	output logic [PW-1:0] pay_out
);

	localparam int HW = NW - QW;
	localparam int CW = (HW > DW) ? HW : DW;

	logic [CW-1:0] hi_ext;
	logic [CW-1:0] den_ext;

	logic [QW:0]   v_s;
	logic [QW:0]   sat_s;
	logic [DW-1:0] rem_s [QW+1];
	logic [QW-1:0] lq_s  [QW+1];
	logic [DW-1:0] den_s [QW+1];
	logic [PW-1:0] pay_s [QW+1];

	logic [DW-1:0] rem_nx [QW];
	logic [QW-1:0] lq_nx  [QW];

	assign hi_ext  = CW'(num[NW-1:QW]);
	assign den_ext = CW'(den);

	for (genvar j = 0; j < QW; j++) begin : g_step
		logic [DW:0] t_w;
		logic [DW:0] diff_w;
		logic        ge_w;
		assign t_w       = {rem_s[j], lq_s[j][QW-1]};
		assign ge_w      = t_w >= {1'b0, den_s[j]};
		assign diff_w    = t_w - {1'b0, den_s[j]};
		assign rem_nx[j] = ge_w ? diff_w[DW-1:0] : t_w[DW-1:0];
		assign lq_nx[j]  = {lq_s[j][QW-2:0], ge_w};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[QW-1:0], v_in};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= hi_ext[DW-1:0];
			lq_s[0]  <= num[QW-1:0];
			sat_s    <= {sat_s[QW-1:0], hi_ext >= den_ext};
			den_s[0] <= den;
			pay_s[0] <= pay_in;
			for (int j = 1; j <= QW; j++) begin
				rem_s[j] <= rem_nx[j-1];
				lq_s[j]  <= lq_nx[j-1];
				den_s[j] <= den_s[j-1];
				pay_s[j] <= pay_s[j-1];
			end
		end
	end

	assign v_out   = v_s[QW];
	assign quo     = sat_s[QW] ? '1 : lq_s[QW];
	assign pay_out = pay_s[QW];

endmodule

// ===== design/rerl_sqrt.sv =====
// rerl_sqrt: pipelined integer square root, one root bit per stage
// standalone; used by resolved_energy_ratio_limiter
`timescale 1ns / 1ps
module rerl_sqrt #(
	parameter int IW = 32,
	parameter int PW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            v_in,
	input  logic [2*IW-1:0] rad,
	input  logic [PW-1:0]   pay_in,
	output logic            v_out,
	output logic [IW-1:0]   root,
	output logic [PW-1:0]   pay_out
);

	logic [IW:0]     v_s;
	logic [IW+1:0]   rem_s  [IW+1];
	logic [IW-1:0]   root_s [IW+1];
	logic [2*IW-1:0] rad_s  [IW+1];
	logic [PW-1:0]   pay_s  [IW+1];

	logic [IW+1:0]   rem_nx  [IW];
	logic [IW-1:0]   root_nx [IW];

	for (genvar j = 0; j < IW; j++) begin : g_step
		logic [IW+3:0] t_w;
		logic [IW+3:0] trial_w;
		logic [IW+3:0] diff_w;
		logic          ge_w;
		assign t_w        = {rem_s[j], rad_s[j][2*IW-1:2*IW-2]};
		assign trial_w    = (IW+4)'({root_s[j], 2'b01});
		assign ge_w       = t_w >= trial_w;
		assign diff_w     = t_w - trial_w;
		assign rem_nx[j]  = ge_w ? diff_w[IW+1:0] : t_w[IW+1:0];
		assign root_nx[j] = {root_s[j][IW-2:0], ge_w};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[IW-1:0], v_in};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= '0;
			root_s[0] <= '0;
			rad_s[0]  <= rad;
			pay_s[0]  <= pay_in;
			for (int j = 1; j <= IW; j++) begin
				rem_s[j]  <= rem_nx[j-1];
				root_s[j] <= root_nx[j-1];
				rad_s[j]  <= {rad_s[j-1][2*IW-3:0], 2'b00};
				pay_s[j]  <= pay_s[j-1];
			end
		end
	end

	assign v_out   = v_s[IW];
	assign root    = root_s[IW];
	assign pay_out = pay_s[IW];

endmodule

// ===== design/resolved_energy_ratio_limiter.sv =====
// resolved_energy_ratio_limiter: unresolved energy ratio with Kolmogorov floor
// depends on rerl_pkg, rerl_if, rerl_div and rerl_sqrt
//
//   channel  dir  handshake      payload
//   nodes    in   valid/ready    kinetic_energy .. eddy_viscosity, FIELD_WIDTH each
//   ratios   out  valid/ready    energy_ratio, FRACTION_BITS+1
//   cfg      in   valid/ready    data = dissipation_floor, always ready
//
// one node request per cycle while the output skid register is empty; the pipeline is
// a chain of bit-per-stage dividers (three of SAT_W stages) and the root.
// reset clears valid bits and sets the floor to one lsb; no clearing pass.
// a stall stops the whole pipeline once the output skid register fills; the
// output register still holds one result while the next request is taken.
`timescale 1ns / 1ps
module resolved_energy_ratio_limiter #(
	parameter int FIELD_WIDTH   = 32,
	parameter int FRACTION_BITS = 16
) (
	input logic             clk,
	input logic             arst_n,
	rerl_in_if.sink         nodes,
	rerl_out_if.source      ratios,
	rerl_cfg_if.sink        cfg
);

	localparam int W   = FIELD_WIDTH;
	localparam int F   = FRACTION_BITS;
	localparam int SW  = rerl_pkg::SAT_W;
	localparam int HS  = rerl_pkg::HALF_W;
	localparam int DMW = (W > F + 1) ? W : F + 1;
	localparam int XW  = F + rerl_pkg::KOL_NUM_W;
	localparam logic [F:0]    ONE = (F+1)'(1) << F;
	localparam logic [SW-1:0] KOL_TH =
		((SW'(rerl_pkg::KOL_DEN) << F) + SW'(rerl_pkg::KOL_NUM - 1)) / SW'(rerl_pkg::KOL_NUM);
	localparam int KS   = XW + rerl_pkg::KOL_DEN_W;
	localparam int KPW  = 2*XW + 1;
	localparam logic [XW:0] KM = (XW+1)'(((64'd1 << KS) + 64'(rerl_pkg::KOL_DEN - 1)) /
		64'(rerl_pkg::KOL_DEN));

	logic en;
	logic [F:0] floor_q;

	// output register and skid
	logic       ov_q, sv_q;
	logic [F:0] od_q, sd_q;

	assign en          = !sv_q;
	assign nodes.ready = en;
	assign cfg.ready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q <= (F+1)'(1);
		end else if (cfg.valid) begin
			floor_q <= cfg.data;
		end
	end

	// stage 1: capture and clamp
	logic           v_s1;
	logic [W-1:0]   k_s1, r_s1, t_s1, vm_s1, e_s1;
	logic [DMW-1:0] d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= nodes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k_s1  <= nodes.kinetic_energy;
			r_s1  <= nodes.resolved_energy;
			t_s1  <= nodes.dissipation_rate;
			vm_s1 <= nodes.molecular_viscosity;
			e_s1  <= nodes.eddy_viscosity;
			d_s1  <= (DMW'(nodes.dissipation_rate) > DMW'(floor_q)) ?
				DMW'(nodes.dissipation_rate) : DMW'(floor_q);
		end
	end

	// stage 2: products
	logic             v_s2, zk_s2, rge_s2;
	logic [W-1:0]     k_s2, r_s2;
	logic [2*W-1:0]   vt_s2;
	logic [W+DMW-1:0] ed_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k_s2   <= k_s1;
			r_s2   <= r_s1;
			zk_s2  <= k_s1 == '0;
			rge_s2 <= r_s1 >= k_s1;
			vt_s2  <= (2*W)'(vm_s1) * (2*W)'(t_s1);
			ed_s2  <= (W+DMW)'(e_s1) * (W+DMW)'(d_s1);
		end
	end

	// resolved share
	localparam int PA = W + 2*W + W + DMW + 2;
	logic             v_a;
	logic [F-1:0]     ratio_a;
	logic [W-1:0]     k_a;
	logic [2*W-1:0]   vt_a;
	logic [W+DMW-1:0] ed_a;
	logic             zk_a, rge_a;
	logic [F:0]       base_a;

	rerl_div #(.NW(W + F), .DW(W), .QW(F), .PW(PA)) u_div_ratio (
		.clk(clk), .arst_n(arst_n), .en(en), .v_in(v_s2),
		.num({r_s2, F'(0)}), .den(k_s2),
		.pay_in({k_s2, vt_s2, ed_s2, zk_s2, rge_s2}),
		.v_out(v_a), .quo(ratio_a),
		.pay_out({k_a, vt_a, ed_a, zk_a, rge_a})
	);

	assign base_a = rge_a ? '0 : ONE - {1'b0, ratio_a};

	// square root of viscosity times dissipation
	localparam int PB = W + W + DMW + 1 + F + 1;
	logic             v_b;
	logic [W-1:0]     s_b, k_b;
	logic [W+DMW-1:0] ed_b;
	logic             zk_b;
	logic [F:0]       base_b;

	rerl_sqrt #(.IW(W), .PW(PB)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .v_in(v_a), .rad(vt_a),
		.pay_in({k_a, ed_a, zk_a, base_a}),
		.v_out(v_b), .root(s_b),
		.pay_out({k_b, ed_b, zk_b, base_b})
	);

	// q1 = eddy * clamped dissipation / k
	localparam int PC = W + W + 1 + F + 1;
	logic          v_c;
	logic [SW-1:0] q1_c;
	logic [W-1:0]  k_c, s_c;
	logic          zk_c;
	logic [F:0]    base_c;

	rerl_div #(.NW(SW + W), .DW(W), .QW(SW), .PW(PC)) u_div_q1 (
		.clk(clk), .arst_n(arst_n), .en(en), .v_in(v_b),
		.num((SW+W)'(ed_b)), .den(k_b),
		.pay_in({k_b, s_b, zk_b, base_b}),
		.v_out(v_c), .quo(q1_c),
		.pay_out({k_c, s_c, zk_c, base_c})
	);

	// q1 * s in two partial products
	logic             v_s3, v_s4, zk_s3, zk_s4;
	logic [HS+W-1:0]  plo_s3, phi_s3;
	logic [W-1:0]     k_s3, k_s4;
	logic [F:0]       base_s3, base_s4;
	logic [SW+W-1:0]  prod_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_c;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			plo_s3  <= (HS+W)'(q1_c[HS-1:0]) * (HS+W)'(s_c);
			phi_s3  <= (HS+W)'(q1_c[SW-1:HS]) * (HS+W)'(s_c);
			k_s3    <= k_c;
			zk_s3   <= zk_c;
			base_s3 <= base_c;
			prod_s4 <= (SW+W)'(plo_s3) + ((SW+W)'(phi_s3) << HS);
			k_s4    <= k_s3;
			zk_s4   <= zk_s3;
			base_s4 <= base_s3;
		end
	end

	// q2 = q1 * s / k
	localparam int PD = W + 1 + F + 1;
	logic          v_d;
	logic [SW-1:0] q2_d;
	logic [W-1:0]  k_d;
	logic          zk_d;
	logic [F:0]    base_d;

	rerl_div #(.NW(SW + W), .DW(W), .QW(SW), .PW(PD)) u_div_q2 (
		.clk(clk), .arst_n(arst_n), .en(en), .v_in(v_s4),
		.num(prod_s4), .den(k_s4),
		.pay_in({k_s4, zk_s4, base_s4}),
		.v_out(v_d), .quo(q2_d),
		.pay_out({k_d, zk_d, base_d})
	);

	// q3 = q2 * one / k
	localparam int PE = 1 + F + 1;
	logic          v_e;
	logic [SW-1:0] q3_e;
	logic          zk_e;
	logic [F:0]    base_e;

	rerl_div #(.NW(SW + F), .DW(W), .QW(SW), .PW(PE)) u_div_q3 (
		.clk(clk), .arst_n(arst_n), .en(en), .v_in(v_d),
		.num({q2_d, F'(0)}), .den(k_d),
		.pay_in({zk_d, base_d}),
		.v_out(v_e), .quo(q3_e),
		.pay_out({zk_e, base_e})
	);

	// stage 5: kolmogorov scale, saturation check
	logic          v_s5, big_s5, zk_s5;
	logic [XW-1:0] x_s5;
	logic [F:0]    base_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_e;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			big_s5  <= q3_e >= KOL_TH;
			x_s5    <= XW'(q3_e[F-1:0]) * XW'(rerl_pkg::KOL_NUM);
			zk_s5   <= zk_e;
			base_s5 <= base_e;
		end
	end

	// stage 6: divide by eleven through a reciprocal product
	logic           v_s6, big_s6, zk_s6;
	logic [F-1:0]   akol_s6;
	logic [F:0]     base_s6;
	logic [KPW-1:0] kp_w;
	logic [F:0]     akol_w;

	assign kp_w = KPW'(x_s5) * KPW'(KM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			akol_s6 <= kp_w[KS+F-1:KS];
			big_s6  <= big_s5;
			zk_s6   <= zk_s5;
			base_s6 <= base_s5;
		end
	end

	assign akol_w = big_s6 ? ONE : {1'b0, akol_s6};

	// stage 7: final select
	logic       v_s7;
	logic [F:0] ratio_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ratio_s7 <= zk_s6 ? ONE : ((base_s6 > akol_w) ? base_s6 : akol_w);
		end
	end

	// output register with skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sv_q <= 1'b0;
		end else if (en && v_s7) begin
			if (ov_q && !ratios.ready) begin
				sv_q <= 1'b1;
			end else begin
				ov_q <= 1'b1;
			end
		end else if (!ov_q || ratios.ready) begin
			ov_q <= sv_q;
			sv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s7) begin
			if (ov_q && !ratios.ready) begin
				sd_q <= ratio_s7;
			end else begin
				od_q <= ratio_s7;
			end
		end else if (!ov_q || ratios.ready) begin
			od_q <= sd_q;
		end
	end

	assign ratios.valid        = ov_q;
	assign ratios.energy_ratio = od_q;

endmodule

// ===== test/rerl_checker.sv =====
// rerl_checker: watches the node, ratio and floor channels, predicts each ratio and compares
// depends on rerl_if (interfaces); predictor written from the block's fixed-point definition
`timescale 1ns / 1ps
module rerl_checker #(
	parameter int FIELD_WIDTH   = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	rerl_in_if.sink     nodes,
	rerl_out_if.sink    ratios,
	rerl_cfg_if.sink    cfg,
	output int          fail_count,
	output int          pending,
	output int          ratio_count
);
	localparam logic [63:0] ONE_Q = 64'd1 << FRACTION_BITS;

	logic [FRACTION_BITS:0] floor_reg;
	logic [FRACTION_BITS:0] ratio_queue[$];

	function automatic logic [63:0] mul_div_sat(logic [63:0] a, logic [63:0] b, logic [63:0] den);
		logic [127:0] p;
		logic [127:0] q;
		p = a * b;
		q = p / den;
		if (q[127:64] != 0) return '1;
		return q[63:0];
	endfunction

	function automatic logic [63:0] isqrt128(logic [127:0] n);
		logic [63:0] r;
		logic [63:0] c;
		r = 0;
		for (int i = 63; i >= 0; i--) begin
			c = r | (64'd1 << i);
			if (128'(c) * 128'(c) <= n) r = c;
		end
		return r;
	endfunction

	function automatic logic [FRACTION_BITS:0] predict_ratio(logic [63:0] k, logic [63:0] res,
			logic [63:0] t, logic [63:0] v, logic [63:0] e, logic [63:0] fl);
		logic [63:0] ratio, base, d, s, q, akol;
		if (k == 0) return ONE_Q[FRACTION_BITS:0];
		ratio = mul_div_sat(res, ONE_Q, k);
		if (ratio > ONE_Q) ratio = ONE_Q;
		base = ONE_Q - ratio;
		d = (t > fl) ? t : fl;
		s = isqrt128(128'(v) * 128'(t));
		q = mul_div_sat(e, d, k);
		q = mul_div_sat(q, s, k);
		q = mul_div_sat(q, ONE_Q, k);
		akol = mul_div_sat(q, 64'd75, 64'd11);
		if (akol > ONE_Q) akol = ONE_Q;
		return (base > akol) ? base[FRACTION_BITS:0] : akol[FRACTION_BITS:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_reg <= 1;
			fail_count <= 0;
			ratio_count <= 0;
			pending <= 0;
			ratio_queue.delete();
		end else begin
			if (cfg.valid && cfg.ready) floor_reg <= cfg.data;
			if (nodes.valid && nodes.ready)
				ratio_queue.push_back(predict_ratio(64'(nodes.kinetic_energy),
					64'(nodes.resolved_energy), 64'(nodes.dissipation_rate),
					64'(nodes.molecular_viscosity), 64'(nodes.eddy_viscosity),
					64'(floor_reg)));
			if (ratios.valid && ratios.ready) begin
				ratio_count <= ratio_count + 1;
				if (ratio_queue.size() == 0) begin
					if (fail_count < 10) $display("unexpected ratio %0d", ratios.energy_ratio);
					fail_count <= fail_count + 1;
				end else begin
					if (ratio_queue[0] !== ratios.energy_ratio) begin
						if (fail_count < 10)
							$display("ratio %0d: expected %0d, got %0d", ratio_count,
								ratio_queue[0], ratios.energy_ratio);
						fail_count <= fail_count + 1;
					end
					void'(ratio_queue.pop_front());
				end
			end
			pending <= ratio_queue.size();
		end
	end
endmodule

// ===== test/tb_top.sv =====
// tb_top: drives node requests and floor writes into the limiter, stalls the result side
// depends on rerl_if, resolved_energy_ratio_limiter and rerl_checker
`timescale 1ns / 1ps
module tb_top;
	localparam int FW = 32;
	localparam int FB = 16;
	localparam int LATENCY = FB + FW + 205;
	localparam longint LIMIT = 2000000;

	logic clk;
	logic arst_n;
	int fail_count, pending, ratio_count;
	longint cycle;
	int nodes_sent;

	rerl_in_if  #(.FIELD_WIDTH(FW))   nodes ();
	rerl_out_if #(.FRACTION_BITS(FB)) ratios ();
	rerl_cfg_if #(.FRACTION_BITS(FB)) cfg ();

	resolved_energy_ratio_limiter #(.FIELD_WIDTH(FW), .FRACTION_BITS(FB)) u_top (
		.clk(clk), .arst_n(arst_n), .nodes(nodes), .ratios(ratios), .cfg(cfg));

	rerl_checker #(.FIELD_WIDTH(FW), .FRACTION_BITS(FB)) u_checker (
		.clk(clk), .arst_n(arst_n), .nodes(nodes), .ratios(ratios), .cfg(cfg),
		.fail_count(fail_count), .pending(pending), .ratio_count(ratio_count));

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle = 0;
		forever begin
			@(posedge clk);
			cycle++;
			if (cycle > LIMIT) begin
				$display("timeout after %0d cycles", cycle);
				$display("resolved_energy_ratio_limiter: mismatch");
				$finish;
			end
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// result side stalls
	initial begin
		ratios.ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (cycle < 3000 || $urandom_range(0, 3) != 0) ratios.ready <= 1;
			else begin
				ratios.ready <= 0;
				repeat (gap_len()) @(negedge clk);
				ratios.ready <= 1;
			end
		end
	end

	function automatic logic [31:0] rand_field();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(0, 65535);
			3: return $urandom_range(0, 32'h000F_FFFF);
			default: return $urandom();
		endcase
	endfunction

	task automatic send_node(logic [31:0] k, logic [31:0] r, logic [31:0] t,
			logic [31:0] v, logic [31:0] e);
		nodes.valid <= 1;
		nodes.kinetic_energy <= k;
		nodes.resolved_energy <= r;
		nodes.dissipation_rate <= t;
		nodes.molecular_viscosity <= v;
		nodes.eddy_viscosity <= e;
		do @(posedge clk); while (!nodes.ready);
		@(negedge clk);
		nodes_sent++;
	endtask

	task automatic idle_node(int n);
		nodes.valid <= 0;
		repeat (n) @(negedge clk);
	endtask

	task automatic drain();
		nodes.valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
	endtask

	task automatic write_floor(logic [FB:0] val);
		cfg.valid <= 1;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 0;
	endtask

	task automatic random_phase(int n);
		logic [31:0] k;
		for (int i = 0; i < n; i++) begin
			k = rand_field();
			if ($urandom_range(0, 3) == 0) k = $urandom_range(1, 16);
			send_node(k, ($urandom_range(0, 1) ? $urandom_range(0, k) : rand_field()),
				rand_field(), rand_field(), rand_field());
			if ($urandom_range(0, 2) == 0) idle_node(gap_len());
		end
	endtask

	initial begin
		logic [FB:0] floors[4];
		nodes_sent = 0;
		arst_n = 0;
		nodes.valid = 0;
		nodes.kinetic_energy = 0;
		nodes.resolved_energy = 0;
		nodes.dissipation_rate = 0;
		nodes.molecular_viscosity = 0;
		nodes.eddy_viscosity = 0;
		cfg.valid = 0;
		cfg.data = 0;
		repeat (10) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: zero energy, resolved above total, extremes, kolmogorov floor
		send_node(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_node(0, 0, 0, 0, 0);
		send_node(32'h0001_0000, 32'h0002_0000, 0, 0, 0);
		send_node(32'h0001_0000, 32'h0000_8000, 0, 0, 0);
		send_node(32'h0001_0000, 32'h0001_0000, 0, 0, 0);
		send_node(32'hFFFF_FFFF, 0, 0, 0, 0);
		send_node(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_node(1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_node(1, 1, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_node(32'h0001_0000, 32'h0001_0000, 32'h0000_0100, 32'h0000_0100, 32'h0000_1000);
		send_node(32'h0000_1000, 32'h0000_1000, 32'h0001_0000, 32'h0001_0000, 32'h0000_0400);
		send_node(32'h0000_4000, 32'h0000_3000, 32'h0010_0000, 32'h0000_0010, 32'h0000_0800);
		drain();

		floors[0] = 0;
		floors[1] = 17'h1_0000;
		floors[2] = 17'h1_FFFF;
		floors[3] = 1;
		for (int p = 0; p < 4; p++) begin
			write_floor(floors[p]);
			send_node(32'h0001_0000, 32'h0001_0000, 0, 32'h0001_0000, 32'h0001_0000);
			send_node(32'h0000_1000, 32'h0000_1000, 1, 32'h0010_0000, 32'h0000_1000);
			random_phase(60);
			drain();
		end
		for (int p = 0; p < 4; p++) begin
			write_floor((FB+1)'($urandom_range(0, 17'h1_FFFF)));
			random_phase(200);
			drain();
		end

		$display("sent %0d node requests, checked %0d ratios over several floor settings",
			nodes_sent, ratio_count);
		if (fail_count == 0) $display("resolved_energy_ratio_limiter: match");
		else $display("resolved_energy_ratio_limiter: mismatch");
		$finish;
	end
endmodule
